// File: sv/kot_pkg.sv
// Shared types, token and error codes, and the keyword table of the tokenizer.
`default_nettype none
package kot_pkg;

   localparam int PREFIX_DEPTH = 6;
   localparam int KW_COUNT = 15;

   typedef logic [PREFIX_DEPTH-1:0][7:0] prefix_type;

   // Queue handshake between the scanner and the result queue.
   typedef struct packed {
      logic push0;
      logic push1;
   } push_type;

   typedef struct packed {
      logic space;
   } queue_status_type;

   // Token kinds.
   localparam logic [5:0] KIND_NONE    = 6'd0;
   localparam logic [5:0] KIND_IDENT   = 6'd15;
   localparam logic [5:0] KIND_INT     = 6'd16;
   localparam logic [5:0] KIND_DEC     = 6'd17;
   localparam logic [5:0] KIND_LBRACE  = 6'd18;
   localparam logic [5:0] KIND_RBRACE  = 6'd19;
   localparam logic [5:0] KIND_LPAREN  = 6'd20;
   localparam logic [5:0] KIND_RPAREN  = 6'd21;
   localparam logic [5:0] KIND_LBRACK  = 6'd22;
   localparam logic [5:0] KIND_RBRACK  = 6'd23;
   localparam logic [5:0] KIND_COMMA   = 6'd24;
   localparam logic [5:0] KIND_SEMI    = 6'd25;
   localparam logic [5:0] KIND_ASSIGN  = 6'd26;
   localparam logic [5:0] KIND_EQ      = 6'd27;
   localparam logic [5:0] KIND_NE      = 6'd28;
   localparam logic [5:0] KIND_LT      = 6'd29;
   localparam logic [5:0] KIND_LE      = 6'd30;
   localparam logic [5:0] KIND_GT      = 6'd31;
   localparam logic [5:0] KIND_GE      = 6'd32;
   localparam logic [5:0] KIND_AND     = 6'd33;
   localparam logic [5:0] KIND_OR      = 6'd34;
   localparam logic [5:0] KIND_PLUS    = 6'd35;
   localparam logic [5:0] KIND_MINUS   = 6'd36;
   localparam logic [5:0] KIND_MULT    = 6'd37;
   localparam logic [5:0] KIND_DIV     = 6'd38;
   localparam logic [5:0] KIND_INC     = 6'd39;
   localparam logic [5:0] KIND_DECR    = 6'd40;
   localparam logic [5:0] KIND_EOF     = 6'd41;

   // Error codes.
   localparam logic [2:0] ERR_NONE  = 3'd0;
   localparam logic [2:0] ERR_CHAR  = 3'd1;
   localparam logic [2:0] ERR_AMP   = 3'd2;
   localparam logic [2:0] ERR_BAR   = 3'd3;
   localparam logic [2:0] ERR_BANG  = 3'd4;

   // Characters with a meaning of their own.
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_BAR   = 8'h7C;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;

   // Keyword text, first character in the low byte.
   localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
      48'("niam"), 48'("diov"), 48'("tni"), 48'("taolf"), 48'("rahc"),
      48'("fi"), 48'("esle"), 48'("elihw"), 48'("daer"), 48'("tnirp"),
      48'("rof"), 48'("srav"), 48'("smarap"), 48'("ini"), 48'("ot")
   };
   localparam logic [2:0] KW_LEN [KW_COUNT] = '{
      3'd4, 3'd4, 3'd3, 3'd5, 3'd4, 3'd2, 3'd4, 3'd5,
      3'd4, 3'd5, 3'd3, 3'd4, 3'd6, 3'd3, 3'd2
   };

   function automatic logic is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   // Keyword kind for a lexeme of n stored characters, or identifier.
   function automatic logic [5:0] keyword_kind(prefix_type p, logic [2:0] n);
      logic [5:0] k;
      logic       hit;
      k = KIND_IDENT;
      for (int i = 0; i < KW_COUNT; i++) begin
         hit = (KW_LEN[i] == n);
         for (int j = 0; j < PREFIX_DEPTH; j++) begin
            if (j < int'(n) && p[j] != KW_TEXT[i][8*j +: 8]) hit = 1'b0;
         end
         if (hit) k = 6'(i);
      end
      return k;
   endfunction

endpackage
`default_nettype wire

// File: sv/kot_if.sv
// Stream interfaces for source characters and tokens.
`default_nettype none
interface kot_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;
   logic       end_of_input;
   modport source (output valid, character, end_of_input, input ready);
   modport sink (input valid, character, end_of_input, output ready);
endinterface

interface kot_rsp_if #(
   parameter int POS_BITS = 16,
   parameter int LINE_BITS = 16,
   parameter int LEN_BITS = 8
);
   logic                 valid;
   logic                 ready;
   logic [5:0]           token_kind;
   logic [2:0]           error_code;
   logic [LINE_BITS-1:0] line_number;
   logic [POS_BITS-1:0]  start_offset;
   logic [LEN_BITS-1:0]  lexeme_length;
   logic [7:0]           bad_character;
   logic                 last;
   modport source (output valid, token_kind, error_code, line_number, start_offset,
                   lexeme_length, bad_character, last, input ready);
   modport sink (input valid, token_kind, error_code, line_number, start_offset,
                 lexeme_length, bad_character, last, output ready);
endinterface
`default_nettype wire

// File: sv/kot_front.sv
// Scanner state machine: classifies each character and builds up to two tokens.
`default_nettype none
module kot_front #(
   parameter int POS_BITS = 16,
   parameter int LINE_BITS = 16,
   parameter int LEN_BITS = 8,
   parameter int W = 6 + 3 + LINE_BITS + POS_BITS + LEN_BITS + 8 + 1
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       accept,
   input  wire [7:0]                 character,
   input  wire                       end_of_input,
   output kot_pkg::push_type         push,
   output logic [W-1:0]              data0,
   output logic [W-1:0]              data1
);
   import kot_pkg::*;

   typedef enum logic [3:0] {
      S_START, S_IDENT, S_INTEGER, S_DECIMAL, S_AMP, S_BAR, S_EQ, S_BANG,
      S_LT, S_GT, S_PLUS, S_MINUS, S_CR
   } state_type;

   localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};
   localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
   localparam logic [LEN_BITS-1:0] LEN_ONE = LEN_BITS'(1);
   localparam logic [LEN_BITS-1:0] LEN_TWO = LEN_BITS'(2);

   state_type            state_ff, state_in;
   prefix_type           prefix_ff, prefix_in;
   logic [LEN_BITS-1:0]  count_ff, count_in;
   logic [POS_BITS-1:0]  tstart_ff, tstart_in;
   logic [POS_BITS-1:0]  pos_ff, pos_in;
   logic [LINE_BITS-1:0] line_ff, line_in;

   // Token fields: a is the flush or pair token, b the token begun now.
   logic                 a_v, b_v, fl_v, sc_v, sc_begin, sc_nl, done, pair_hit;
   logic [5:0]           fl_kind, sc_kind, a_kind, b_kind;
   logic [2:0]           fl_err, sc_err, a_err, b_err;
   logic [LEN_BITS-1:0]  fl_len, a_len, b_len;
   logic [POS_BITS-1:0]  a_start, b_start;
   logic [7:0]           sc_bad, b_bad, pair_char;
   logic [5:0]           pair_kind;
   state_type            sc_state;
   logic                 kw_ok;
   logic [W-1:0]         a_data, b_data;

   // Token that the current state holds, if the lexeme ends here.
   always_comb begin
      kw_ok = (count_ff <= LEN_BITS'(PREFIX_DEPTH)) && (count_ff != LEN_MAX);
      fl_v = 1'b1;
      fl_err = ERR_NONE;
      fl_len = LEN_ONE;
      fl_kind = KIND_NONE;
      pair_char = CH_EQ;
      pair_kind = KIND_EQ;
      unique case (state_ff)
         S_IDENT: begin
            fl_kind = kw_ok ? keyword_kind(prefix_ff, count_ff[2:0]) : KIND_IDENT;
            fl_len = count_ff;
         end
         S_INTEGER: begin fl_kind = KIND_INT; fl_len = count_ff; end
         S_DECIMAL: begin fl_kind = KIND_DEC; fl_len = count_ff; end
         S_AMP:   begin fl_err = ERR_AMP; pair_char = CH_AMP; pair_kind = KIND_AND; end
         S_BAR:   begin fl_err = ERR_BAR; pair_char = CH_BAR; pair_kind = KIND_OR; end
         S_BANG:  begin fl_err = ERR_BANG; pair_kind = KIND_NE; end
         S_EQ:    fl_kind = KIND_ASSIGN;
         S_LT:    begin fl_kind = KIND_LT; pair_kind = KIND_LE; end
         S_GT:    begin fl_kind = KIND_GT; pair_kind = KIND_GE; end
         S_PLUS:  begin fl_kind = KIND_PLUS; pair_char = CH_PLUS; pair_kind = KIND_INC; end
         S_MINUS: begin fl_kind = KIND_MINUS; pair_char = CH_MINUS; pair_kind = KIND_DECR; end
         default: fl_v = 1'b0;
      endcase
   end

   // Classification of a character seen from the start state.
   always_comb begin
      sc_v = 1'b1;
      sc_kind = KIND_NONE;
      sc_err = ERR_NONE;
      sc_bad = 8'd0;
      sc_begin = 1'b0;
      sc_nl = 1'b0;
      sc_state = S_START;
      unique case (character)
         "{": sc_kind = KIND_LBRACE;
         "}": sc_kind = KIND_RBRACE;
         "(": sc_kind = KIND_LPAREN;
         ")": sc_kind = KIND_RPAREN;
         "[": sc_kind = KIND_LBRACK;
         "]": sc_kind = KIND_RBRACK;
         ",": sc_kind = KIND_COMMA;
         ";": sc_kind = KIND_SEMI;
         "*": sc_kind = KIND_MULT;
         "/": sc_kind = KIND_DIV;
         CH_AMP:   begin sc_v = 1'b0; sc_begin = 1'b1; sc_state = S_AMP; end
         CH_BAR:   begin sc_v = 1'b0; sc_begin = 1'b1; sc_state = S_BAR; end
         CH_EQ:    begin sc_v = 1'b0; sc_begin = 1'b1; sc_state = S_EQ; end
         CH_BANG:  begin sc_v = 1'b0; sc_begin = 1'b1; sc_state = S_BANG; end
         CH_LT:    begin sc_v = 1'b0; sc_begin = 1'b1; sc_state = S_LT; end
         CH_GT:    begin sc_v = 1'b0; sc_begin = 1'b1; sc_state = S_GT; end
         CH_PLUS:  begin sc_v = 1'b0; sc_begin = 1'b1; sc_state = S_PLUS; end
         CH_MINUS: begin sc_v = 1'b0; sc_begin = 1'b1; sc_state = S_MINUS; end
         CH_LF:    begin sc_v = 1'b0; sc_nl = 1'b1; end
         CH_CR:    begin sc_v = 1'b0; sc_nl = 1'b1; sc_state = S_CR; end
         CH_SPACE, CH_TAB: sc_v = 1'b0;
         default: begin
            if (is_letter(character)) begin
               sc_v = 1'b0; sc_begin = 1'b1; sc_state = S_IDENT;
            end else if (is_digit(character)) begin
               sc_v = 1'b0; sc_begin = 1'b1; sc_state = S_INTEGER;
            end else begin
               sc_err = ERR_CHAR;
               sc_bad = character;
            end
         end
      endcase
   end

   // Next state and the tokens of this beat.
   always_comb begin
      state_in = state_ff;
      prefix_in = prefix_ff;
      count_in = count_ff;
      tstart_in = tstart_ff;
      pos_in = pos_ff;
      line_in = line_ff;
      a_v = 1'b0;
      a_kind = fl_kind;
      a_err = fl_err;
      a_len = fl_len;
      a_start = tstart_ff;
      b_v = 1'b0;
      b_kind = sc_kind;
      b_err = sc_err;
      b_len = LEN_ONE;
      b_start = pos_ff;
      b_bad = sc_bad;
      done = 1'b0;
      pair_hit = 1'b0;
      unique case (state_ff)
         S_IDENT: done = is_letter(character) || is_digit(character) ||
                         character == CH_UNDER;
         S_INTEGER: done = is_digit(character) || character == CH_DOT;
         S_DECIMAL: done = is_digit(character);
         S_AMP, S_BAR, S_EQ, S_BANG, S_LT, S_GT, S_PLUS, S_MINUS: begin
            pair_hit = (character == pair_char);
            done = pair_hit;
         end
         S_CR: done = (character == CH_LF);
         default: done = 1'b0;
      endcase
      if (accept) begin
         if (end_of_input) begin
            a_v = fl_v;
            b_v = 1'b1;
            b_kind = KIND_EOF;
            b_err = ERR_NONE;
            b_len = '0;
            b_bad = 8'd0;
            state_in = S_START;
            prefix_in = '0;
            count_in = '0;
            tstart_in = '0;
            pos_in = '0;
            line_in = LINE_BITS'(1);
         end else begin
            pos_in = pos_ff + POS_BITS'(1);
            if (done) begin
               if (pair_hit) begin
                  a_v = 1'b1;
                  a_kind = pair_kind;
                  a_err = ERR_NONE;
                  a_len = LEN_TWO;
                  state_in = S_START;
                  count_in = '0;
               end else if (state_ff == S_CR) begin
                  state_in = S_START;
               end else begin
                  // Extend the lexeme; only the first characters are kept.
                  if (count_ff < LEN_BITS'(PREFIX_DEPTH))
                     prefix_in[count_ff[2:0]] = character;
                  if (count_ff != LEN_MAX) count_in = count_ff + LEN_ONE;
                  if (state_ff == S_INTEGER && character == CH_DOT)
                     state_in = S_DECIMAL;
               end
            end else begin
               a_v = fl_v;
               b_v = sc_v;
               state_in = sc_state;
               count_in = sc_begin ? LEN_ONE : '0;
               if (sc_begin) begin
                  tstart_in = pos_ff;
                  prefix_in[0] = character;
               end
               if (sc_nl && line_ff != LINE_MAX) line_in = line_ff + LINE_BITS'(1);
            end
         end
      end
   end

   // Pack the tokens in order and mark the final one.
   always_comb begin
      a_data = {a_kind, a_err, line_ff, a_start, a_len, 8'd0, 1'b0};
      b_data = {b_kind, b_err, line_ff, b_start, b_len, b_bad, 1'b1};
      push.push0 = a_v | b_v;
      push.push1 = a_v & b_v;
      data0 = a_v ? {a_data[W-1:1], ~b_v} : b_data;
      data1 = b_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_START;
         count_ff <= '0;
         tstart_ff <= '0;
         pos_ff <= '0;
         line_ff <= LINE_BITS'(1);
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         tstart_ff <= tstart_in;
         pos_ff <= pos_in;
         line_ff <= line_in;
      end
      prefix_ff <= prefix_in;
   end

endmodule
`default_nettype wire

// File: sv/kot_queue.sv
// Four-entry token queue: up to two entries in per cycle, one out while ready.
`default_nettype none
module kot_queue #(
   parameter int W = 8
) (
   input  wire                          clock,
   input  wire                          reset,
   input  kot_pkg::push_type            push,
   input  wire [W-1:0]                  data0,
   input  wire [W-1:0]                  data1,
   output kot_pkg::queue_status_type    status,
   output logic                         out_valid,
   input  wire                          out_ready,
   output logic [W-1:0]                 out_data
);
   import kot_pkg::*;

   logic [W-1:0] entry_ff [4];
   logic [1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [2:0]   count_ff, count_in;
   logic         pop;

   // Pointer and fill bookkeeping.
   always_comb begin
      pop = out_valid & out_ready;
      wr_in = wr_ff + 2'(push.push0) + 2'(push.push1);
      rd_in = rd_ff + 2'(pop);
      count_in = count_ff + 3'(push.push0) + 3'(push.push1) - 3'(pop);
      out_valid = (count_ff != 3'd0);
      out_data = entry_ff[rd_ff];
      status.space = (count_ff <= 3'd2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
      if (push.push0) entry_ff[wr_ff] <= data0;
      if (push.push1) entry_ff[wr_ff + 2'd1] <= data1;
   end

endmodule
`default_nettype wire

// File: sv/keyword_operator_tokenizer.sv
// Top level of the character-stream tokenizer.
//
// The req channel carries one source byte per beat, or an end_of_input
// beat that flushes any pending token and produces the EOF token. The rsp
// channel carries one token or error per beat; last marks the final result
// caused by an input beat, which may cause zero, one or two results.
// A word, number or operator that may run on is known when the byte after
// it arrives, other results at their own byte; each is written into the
// queue as that byte is taken. The scanner takes one byte per cycle. A
// four-entry queue separates it from the rsp side; the scanner stalls
// while fewer than two entries are free, so bytes that give two results
// each are paced by the one-token per cycle drain of the queue. When the
// receiver stalls, tokens wait in the queue and req ready falls once
// fewer than two entries are free. Reset is synchronous and sets line 1,
// offset 0, the start state and an empty queue.
`default_nettype none
module keyword_operator_tokenizer #(
   parameter int POS_BITS = 16,
   parameter int LINE_BITS = 16,
   parameter int LEN_BITS = 8
) (
   input wire      clock,
   input wire      reset,
   kot_req_if.sink req_bus,
   kot_rsp_if.source rsp_bus
);
   import kot_pkg::*;

   localparam int W = 6 + 3 + LINE_BITS + POS_BITS + LEN_BITS + 8 + 1;

   push_type         push;
   queue_status_type status;
   logic [W-1:0]     data0, data1, out_data;
   logic             accept;

   assign req_bus.ready = status.space;
   assign accept = req_bus.valid & status.space;

   kot_front #(
      .POS_BITS(POS_BITS), .LINE_BITS(LINE_BITS), .LEN_BITS(LEN_BITS), .W(W)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .character(req_bus.character),
      .end_of_input(req_bus.end_of_input),
      .push(push),
      .data0(data0),
      .data1(data1)
   );

   kot_queue #(.W(W)) u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .data0(data0),
      .data1(data1),
      .status(status),
      .out_valid(rsp_bus.valid),
      .out_ready(rsp_bus.ready),
      .out_data(out_data)
   );

   // Unpack the queue head onto the rsp channel.
   assign {rsp_bus.token_kind, rsp_bus.error_code, rsp_bus.line_number,
           rsp_bus.start_offset, rsp_bus.lexeme_length, rsp_bus.bad_character,
           rsp_bus.last} = out_data;

endmodule
`default_nettype wire

// File: sv/kot_checker.sv
// Port-level checks for the tokenizer and their binding to the top level.
`default_nettype none
module kot_checker (
   input wire       clock,
   input wire       reset,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire [5:0] token_kind,
   input wire [2:0] error_code,
   input wire [7:0] bad_character,
   input wire       last,
   input wire       len_zero
);
   import kot_pkg::*;

   // A stalled token beat holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(token_kind) && $stable(last))
      else $error("token beat changed while stalled");

   // Error results carry no token kind.
   a_err_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && error_code != ERR_NONE |-> token_kind == KIND_NONE)
      else $error("error result with a token kind");

   // Only an unrecognized byte reports the byte.
   a_bad: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && bad_character != 8'd0 |-> error_code == ERR_CHAR)
      else $error("bad byte without its error code");

   // End of file is always the final result and has no lexeme.
   a_eof: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && token_kind == KIND_EOF |-> last && len_zero)
      else $error("malformed end of file token");

endmodule

bind keyword_operator_tokenizer kot_checker u_kot_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_bus.valid),
   .rsp_ready(rsp_bus.ready),
   .token_kind(rsp_bus.token_kind),
   .error_code(rsp_bus.error_code),
   .bad_character(rsp_bus.bad_character),
   .last(rsp_bus.last),
   .len_zero(rsp_bus.lexeme_length == '0)
);
`default_nettype wire

// File: test/kot_checker.sv
// Token predictor and scoreboard that watches both tokenizer channels.
`default_nettype none
module kot_scoreboard (
   input wire         clock,
   input wire         reset,
   kot_req_if         req_bus,
   kot_rsp_if         rsp_bus,
   output int         fail_count,
   output int         pending_count,
   output int         token_count
);
   import kot_pkg::*;

   // Scanner states of the predictor.
   typedef enum logic [3:0] {
      SCAN_START, SCAN_IDENT, SCAN_INT, SCAN_DEC, SCAN_AMP, SCAN_BAR, SCAN_EQ,
      SCAN_BANG, SCAN_LT, SCAN_GT, SCAN_PLUS, SCAN_MINUS, SCAN_CR
   } scan_type;

   typedef struct packed {
      logic [5:0]  kind;
      logic [2:0]  err;
      logic [15:0] line;
      logic [15:0] start;
      logic [7:0]  len;
      logic [7:0]  bad;
      logic        last;
   } token_type;

   token_type   token_queue[$];
   scan_type    state;
   prefix_type  prefix;
   logic [7:0]  lex_len;
   logic [15:0] lex_start;
   logic [15:0] position;
   logic [15:0] line_no;
   int          step_base;

   assign pending_count = token_queue.size();

   function automatic logic [5:0] word_kind();
      logic [5:0] k;
      k = KIND_IDENT;
      if (lex_len <= 6 && lex_len != 8'hFF) k = keyword_kind(prefix, 3'(lex_len));
      return k;
   endfunction

   function automatic void push_token(logic [5:0] kind, logic [2:0] err,
                                      logic [15:0] start, logic [7:0] len,
                                      logic [7:0] bad);
      token_type t;
      t = '{kind, err, line_no, start, len, bad, 1'b0};
      token_queue.insert(token_queue.size(), t);
   endfunction

   function automatic void open_lexeme(logic [7:0] c, scan_type next);
      lex_start = position;
      lex_len = 1;
      prefix[0] = c;
      state = next;
   endfunction

   // Emit whatever lexeme is pending and return to the start state.
   function automatic void flush_lexeme();
      case (state)
         SCAN_IDENT: push_token(word_kind(), ERR_NONE, lex_start, lex_len, 0);
         SCAN_INT:   push_token(KIND_INT, ERR_NONE, lex_start, lex_len, 0);
         SCAN_DEC:   push_token(KIND_DEC, ERR_NONE, lex_start, lex_len, 0);
         SCAN_AMP:   push_token(KIND_NONE, ERR_AMP, lex_start, 1, 0);
         SCAN_BAR:   push_token(KIND_NONE, ERR_BAR, lex_start, 1, 0);
         SCAN_BANG:  push_token(KIND_NONE, ERR_BANG, lex_start, 1, 0);
         SCAN_EQ:    push_token(KIND_ASSIGN, ERR_NONE, lex_start, 1, 0);
         SCAN_LT:    push_token(KIND_LT, ERR_NONE, lex_start, 1, 0);
         SCAN_GT:    push_token(KIND_GT, ERR_NONE, lex_start, 1, 0);
         SCAN_PLUS:  push_token(KIND_PLUS, ERR_NONE, lex_start, 1, 0);
         SCAN_MINUS: push_token(KIND_MINUS, ERR_NONE, lex_start, 1, 0);
         default: ;
      endcase
      state = SCAN_START;
      lex_len = 0;
   endfunction

   function automatic void grow(logic [7:0] c);
      if (lex_len < 6) prefix[lex_len] = c;
      if (lex_len != 8'hFF) lex_len++;
   endfunction

   function automatic void next_line();
      if (line_no != 16'hFFFF) line_no++;
   endfunction

   function automatic void start_char(logic [7:0] c);
      case (c)
         "{": push_token(KIND_LBRACE, ERR_NONE, position, 1, 0);
         "}": push_token(KIND_RBRACE, ERR_NONE, position, 1, 0);
         "(": push_token(KIND_LPAREN, ERR_NONE, position, 1, 0);
         ")": push_token(KIND_RPAREN, ERR_NONE, position, 1, 0);
         "[": push_token(KIND_LBRACK, ERR_NONE, position, 1, 0);
         "]": push_token(KIND_RBRACK, ERR_NONE, position, 1, 0);
         ",": push_token(KIND_COMMA, ERR_NONE, position, 1, 0);
         ";": push_token(KIND_SEMI, ERR_NONE, position, 1, 0);
         "*": push_token(KIND_MULT, ERR_NONE, position, 1, 0);
         "/": push_token(KIND_DIV, ERR_NONE, position, 1, 0);
         CH_AMP:   open_lexeme(c, SCAN_AMP);
         CH_BAR:   open_lexeme(c, SCAN_BAR);
         CH_EQ:    open_lexeme(c, SCAN_EQ);
         CH_BANG:  open_lexeme(c, SCAN_BANG);
         CH_LT:    open_lexeme(c, SCAN_LT);
         CH_GT:    open_lexeme(c, SCAN_GT);
         CH_PLUS:  open_lexeme(c, SCAN_PLUS);
         CH_MINUS: open_lexeme(c, SCAN_MINUS);
         CH_LF: next_line();
         CH_CR: begin
            next_line();
            state = SCAN_CR;
         end
         CH_SPACE, CH_TAB: ;
         default: begin
            if (is_letter(c)) open_lexeme(c, SCAN_IDENT);
            else if (is_digit(c)) open_lexeme(c, SCAN_INT);
            else push_token(KIND_NONE, ERR_CHAR, position, 1, c);
         end
      endcase
   endfunction

   // Second byte of a two-byte operator.
   function automatic logic pair_done(logic [7:0] c, logic [7:0] want, logic [5:0] kind);
      if (c != want) return 1'b0;
      push_token(kind, ERR_NONE, lex_start, 2, 0);
      state = SCAN_START;
      lex_len = 0;
      return 1'b1;
   endfunction

   function automatic void clear_state();
      state = SCAN_START;
      prefix = '0;
      lex_len = 0;
      lex_start = 0;
      position = 0;
      line_no = 1;
   endfunction

   // Work out the tokens caused by one accepted beat.
   function automatic void predict_tokens(logic [7:0] c, logic eoi);
      logic taken;
      taken = 1'b0;
      step_base = token_queue.size();
      if (eoi) begin
         flush_lexeme();
         push_token(KIND_EOF, ERR_NONE, position, 0, 0);
         clear_state();
      end else begin
         case (state)
            SCAN_IDENT: if (is_letter(c) || is_digit(c) || c == CH_UNDER) begin
               grow(c);
               taken = 1'b1;
            end
            SCAN_INT: begin
               if (is_digit(c)) begin
                  grow(c);
                  taken = 1'b1;
               end else if (c == CH_DOT) begin
                  grow(c);
                  state = SCAN_DEC;
                  taken = 1'b1;
               end
            end
            SCAN_DEC: if (is_digit(c)) begin
               grow(c);
               taken = 1'b1;
            end
            SCAN_AMP:   taken = pair_done(c, CH_AMP, KIND_AND);
            SCAN_BAR:   taken = pair_done(c, CH_BAR, KIND_OR);
            SCAN_EQ:    taken = pair_done(c, CH_EQ, KIND_EQ);
            SCAN_BANG:  taken = pair_done(c, CH_EQ, KIND_NE);
            SCAN_LT:    taken = pair_done(c, CH_EQ, KIND_LE);
            SCAN_GT:    taken = pair_done(c, CH_EQ, KIND_GE);
            SCAN_PLUS:  taken = pair_done(c, CH_PLUS, KIND_INC);
            SCAN_MINUS: taken = pair_done(c, CH_MINUS, KIND_DECR);
            SCAN_CR: begin
               state = SCAN_START;
               taken = (c == CH_LF);
            end
            default: state = SCAN_START;
         endcase
         if (!taken) begin
            flush_lexeme();
            start_char(c);
         end
         position++;
      end
      if (token_queue.size() > step_base) token_queue[$].last = 1'b1;
   endfunction

   // Compare each result beat with the oldest expected token.
   always @(posedge clock) begin
      token_type want;
      if (reset) begin
         clear_state();
         token_queue.delete();
         fail_count <= 0;
         token_count <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            token_count <= token_count + 1;
            if (token_queue.size() == 0) begin
               $error("unexpected token beat: kind %0d", rsp_bus.token_kind);
               fail_count <= fail_count + 1;
            end else begin
               want = token_queue.pop_front();
               if (rsp_bus.token_kind !== want.kind ||
                   rsp_bus.error_code !== want.err ||
                   rsp_bus.line_number !== want.line ||
                   rsp_bus.start_offset !== want.start ||
                   rsp_bus.lexeme_length !== want.len ||
                   rsp_bus.bad_character !== want.bad ||
                   rsp_bus.last !== want.last) begin
                  fail_count <= fail_count + 1;
                  if (rsp_bus.token_kind !== want.kind)
                     $error("token_kind: expected %0d, got %0d", want.kind, rsp_bus.token_kind);
                  if (rsp_bus.error_code !== want.err)
                     $error("error_code: expected %0d, got %0d", want.err, rsp_bus.error_code);
                  if (rsp_bus.line_number !== want.line)
                     $error("line_number: expected %0d, got %0d", want.line,
                            rsp_bus.line_number);
                  if (rsp_bus.start_offset !== want.start)
                     $error("start_offset: expected %0d, got %0d", want.start,
                            rsp_bus.start_offset);
                  if (rsp_bus.lexeme_length !== want.len)
                     $error("lexeme_length: expected %0d, got %0d", want.len,
                            rsp_bus.lexeme_length);
                  if (rsp_bus.bad_character !== want.bad)
                     $error("bad_character: expected %0d, got %0d", want.bad,
                            rsp_bus.bad_character);
                  if (rsp_bus.last !== want.last)
                     $error("last: expected %0d, got %0d", want.last, rsp_bus.last);
               end
            end
         end
         if (req_bus.valid && req_bus.ready)
            predict_tokens(req_bus.character, req_bus.end_of_input);
      end
   end

endmodule
`default_nettype wire

// File: test/tb_keyword_operator_tokenizer.sv
// Stimulus and verdict for the character-stream tokenizer.
`default_nettype none
module tb_keyword_operator_tokenizer;
   import kot_pkg::*;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   int   token_count;
   int   beat_count;
   int   send_idle;
   int   take_stall;

   kot_req_if req_bus ();
   kot_rsp_if rsp_bus ();

   keyword_operator_tokenizer dut (
      .clock(clock), .reset(reset), .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source)
   );

   kot_scoreboard checker_inst (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .fail_count(fail_count), .pending_count(pending_count), .token_count(token_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit far beyond the slowest correct run.
   initial begin
      #3000000;
      $display("keyword_operator_tokenizer: mismatch");
      $finish;
   end

   // Receiver side: stall at the rate of the current phase.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= take_stall);
      end
   end

   // Send one beat, idling first at the current rate.
   task automatic send_beat(logic [7:0] c, logic eoi);
      while ($urandom_range(99) < send_idle) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.character <= c;
      req_bus.end_of_input <= eoi;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      beat_count++;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
   endtask

   // Pick a fragment of well-formed source, or noise now and then.
   function automatic string source_piece();
      string words[] = '{"main", "void", "int", "float", "char", "if", "else", "while",
                         "read", "print", "for", "vars", "params", "ini", "to", "x1_y",
                         "mainx", "whil", "42", "3.14", "7.", "==", "!=", "<=", ">=",
                         "&&", "||", "++", "--", "=", "<", ">", "+", "-", "*", "/",
                         "{", "}", "(", ")", "[", "]", ",", ";", " ", "\t", "\n",
                         "\r\n", "\r", "&", "|", "!", "_", ".", "@"};
      string s;
      if ($urandom_range(9) == 0) begin
         s = " ";
         s[0] = 8'($urandom_range(255));
         return s;
      end
      return words[$urandom_range(words.size() - 1)];
   endfunction

   initial begin
      logic [7:0] c;
      req_bus.valid = 1'b0;
      req_bus.character = 8'h00;
      req_bus.end_of_input = 1'b0;
      send_idle = 0;
      take_stall = 0;
      beat_count = 0;
      reset = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: keywords, operators, lone operators, CR handling, stray bytes.
      send_text("main(int a){x_1=12.+3.5;}\r\rb\r\n");
      send_text("a!=b&&c||d<=e>=f++--&x|y!z<>=*/[],@_.\tparams to");
      send_beat(8'hFF, 1'b0);
      send_beat(8'h00, 1'b1);
      send_text("==");
      send_beat(8'h00, 1'b1);

      // Random phases with different idle and stall rates.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle = 0;  take_stall = 0;  end
            1: begin send_idle = 86; take_stall = 0;  end
            2: begin send_idle = 0;  take_stall = 86; end
            default: begin send_idle = 10; take_stall = 10; end
         endcase
         for (int n = 0; n < 175; ) begin
            string s;
            s = source_piece();
            send_text(s);
            n += s.len();
            if ($urandom_range(40) == 0) begin
               send_beat(8'($urandom_range(255)), 1'b1);
               n++;
            end
         end
      end

      // A lexeme long enough to saturate the length.
      send_idle = 0;
      take_stall = 0;
      send_beat("a", 1'b0);
      repeat (260) begin
         c = $urandom_range(1) ? "b" : "7";
         send_beat(c, 1'b0);
      end
      send_beat(".", 1'b0);
      send_beat(8'h00, 1'b1);
      req_bus.valid <= 1'b0;

      fork
         wait (pending_count == 0);
         begin
            #2000000;
         end
      join_any
      disable fork;
      repeat (20) @(posedge clock);
      $display("Sent %0d source beats with idle and stall phases; %0d tokens checked.",
               beat_count, token_count);
      if (fail_count == 0 && pending_count == 0)
         $display("keyword_operator_tokenizer: match");
      else
         $display("keyword_operator_tokenizer: mismatch");
      $finish;
   end

endmodule
`default_nettype wire

// File: sim.f
sv/kot_pkg.sv
sv/kot_if.sv
sv/kot_front.sv
sv/kot_queue.sv
sv/keyword_operator_tokenizer.sv
sv/kot_checker.sv
test/kot_checker.sv
test/tb_keyword_operator_tokenizer.sv
